// File: sv/iorb_pkg.sv
// ----------------------------------------------------------------------------
// iorb_pkg
// Shared sizes and types of the in-order release buffer.
// ----------------------------------------------------------------------------
package iorb_pkg;

	localparam int SEQ_W         = 16;
	localparam int PAY_W         = 32;
	localparam int DEPTH_LOG2    = 4;
	localparam int DEPTH         = 1 << DEPTH_LOG2;
	localparam int PAYLOAD_WIDTH = 32;

	typedef logic [SEQ_W-1:0]         seq_t;
	typedef logic [DEPTH_LOG2-1:0]    slot_t;
	typedef logic [PAYLOAD_WIDTH-1:0] store_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DRAIN
	} state_t;

endpackage

// File: sv/iorb_if.sv
// ----------------------------------------------------------------------------
// iorb_in_if / iorb_out_if
// Valid/ready channels of the in-order release buffer: completed items in,
// released or rejected words out.
// ----------------------------------------------------------------------------
interface iorb_in_if import iorb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] seq_id;
	logic [PAY_W-1:0] payload;

	modport source (output valid, output seq_id, output payload, input ready);
	modport sink   (input valid, input seq_id, input payload, output ready);
endinterface

interface iorb_out_if import iorb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PAY_W-1:0] out_payload;
	logic [SEQ_W-1:0] out_seq_id;
	logic             last_of_run;
	logic             rejected;

	modport source (output valid, output out_payload, output out_seq_id,
		output last_of_run, output rejected, input ready);
	modport sink   (input valid, input out_payload, input out_seq_id,
		input last_of_run, input rejected, output ready);
endinterface

// File: sv/in_order_release_buffer.sv
// ----------------------------------------------------------------------------
// in_order_release_buffer
// Takes completed words tagged with a sequence number in any order and
// releases them strictly in sequence order through a slot memory.
//
//   channel   role   fields
//   item      sink   seq_id, payload
//   result    source out_payload, out_seq_id, last_of_run, rejected
//
// Each word is accepted, then evaluated in S_EVAL, which does the slot check
// and the store or first release. A run then drains one stored word per cycle
// while the result register is free, set by the single read port of the slot memory.
// Reset clears the next-expected counter and the per-slot valid flops at once.
// A stalled result register holds a release, reject or drain; a store and a new
// word taken in idle go on even while a result still waits.
// ----------------------------------------------------------------------------
module in_order_release_buffer
	import iorb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	iorb_in_if.sink           item,
	iorb_out_if.source        result
);

	state_t           state_q, state_d;
	seq_t             ne_q, ne_d;
	seq_t             seq_q;
	store_t           pay_q;
	logic [DEPTH-1:0] slot_valid_q;
	store_t           slot_mem [DEPTH];
	store_t           rd_data_q;

	logic             out_valid_q;
	logic [PAY_W-1:0] out_payload_q, out_payload_d;
	seq_t             out_seq_q, out_seq_d;
	logic             out_last_q, out_last_d;
	logic             out_rej_q, out_rej_d;
	logic             out_load;
	logic             out_free;

	logic             mem_we;
	logic             valid_set;
	logic             valid_clr;
	seq_t             seq_dist;
	seq_t             ne_inc;
	slot_t            in_slot;
	slot_t            ne_slot;
	logic             nxt_valid;

	assign out_free  = !out_valid_q || result.ready;
	assign seq_dist  = seq_q - ne_q;
	assign ne_inc    = ne_q + SEQ_W'(1);
	assign in_slot   = seq_q[DEPTH_LOG2-1:0];
	assign ne_slot   = ne_q[DEPTH_LOG2-1:0];
	assign nxt_valid = slot_valid_q[ne_inc[DEPTH_LOG2-1:0]];

	always_comb begin
		state_d       = state_q;
		ne_d          = ne_q;
		item.ready    = 1'b0;
		out_load      = 1'b0;
		out_payload_d = PAY_W'(pay_q);
		out_seq_d     = seq_q;
		out_last_d    = 1'b1;
		out_rej_d     = 1'b0;
		mem_we        = 1'b0;
		valid_set     = 1'b0;
		valid_clr     = 1'b0;
		case (state_q)
			S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (seq_dist == '0) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_last_d = !nxt_valid;
						ne_d       = ne_inc;
						state_d    = nxt_valid ? S_DRAIN : S_IDLE;
					end
				end else if (seq_dist >= SEQ_W'(DEPTH) || slot_valid_q[in_slot]) begin
					if (out_free) begin
						out_load  = 1'b1;
						out_rej_d = 1'b1;
						state_d   = S_IDLE;
					end
				end else begin
					mem_we    = 1'b1;
					valid_set = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_DRAIN: begin
				// rd_data_q tracks the slot of ne_q
				if (out_free) begin
					out_load      = 1'b1;
					out_payload_d = PAY_W'(rd_data_q);
					out_seq_d     = ne_q;
					out_last_d    = !nxt_valid;
					valid_clr     = 1'b1;
					ne_d          = ne_inc;
					state_d       = nxt_valid ? S_DRAIN : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q         <= '0;
			slot_valid_q <= '0;
		end else begin
			ne_q <= ne_d;
			if (valid_set) begin
				slot_valid_q[in_slot] <= 1'b1;
			end
			if (valid_clr) begin
				slot_valid_q[ne_slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			seq_q <= item.seq_id;
			pay_q <= PAYLOAD_WIDTH'(item.payload);
		end
	end

	// stores never hit the slot of the next-expected word, so no forwarding
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[in_slot] <= pay_q;
		end
		rd_data_q <= slot_mem[ne_d[DEPTH_LOG2-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_payload_q <= out_payload_d;
			out_seq_q     <= out_seq_d;
			out_last_q    <= out_last_d;
			out_rej_q     <= out_rej_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_payload = out_payload_q;
	assign result.out_seq_id  = out_seq_q;
	assign result.last_of_run = out_last_q;
	assign result.rejected    = out_rej_q;

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> (state_q == S_EVAL))
		else $error("accepted word not evaluated");

	a_drain_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> slot_valid_q[ne_slot])
		else $error("drain on empty slot");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && out_free) |=> (ne_q == $past(ne_inc)))
		else $error("next-expected did not advance on drain");

	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_rej_d) |=> (result.valid && result.last_of_run))
		else $error("rejected word not marked last");

endmodule
